// ----- rtl/hex_record_checksum_verifier_defines.svh -----
// Assertion macros for the hex record checksum verifier checker.
// Depends on nothing; the asserting file provides i_clk and i_rst_n.
`ifndef HEX_RECORD_CHECKSUM_VERIFIER_DEFINES_SVH
`define HEX_RECORD_CHECKSUM_VERIFIER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define HRCV_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define HRCV_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/hrcv_pkg.sv -----
// Shared types, constants and the hex digit decoder of the record checker.
// Depends on nothing; used by hrcv_ctrl, the top level, the checker and the bench.
package hrcv_pkg;

    localparam logic [15:0] POLY_RESET = 16'h0169;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_CORRUPT = 2'd1;
    localparam logic [1:0] ST_END     = 2'd2;

    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_F = 8'h66;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_F = 8'h46;
    localparam logic [7:0] DIGIT_TEN  = 8'd10;

    localparam logic [1:0]  HDR_SIZE  = 2'd0;
    localparam logic [1:0]  HDR_TYPE  = 2'd3;
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_HEADER,
        PH_DATA,
        PH_CHECK,
        PH_DISCARD
    } t_phase;

    typedef struct packed {
        logic        valid;
        logic [1:0]  status;
        logic [7:0]  calculated;
        logic [7:0]  received;
        logic        mismatch;
        logic [15:0] mismatch_count;
        logic        final_record;
    } t_result;

    // Returns a valid flag above the four-bit digit value.
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [7:0] d;
        logic       ok;
        d  = 8'h00;
        ok = 1'b1;
        if (c inside {[CH_ZERO:CH_NINE]}) begin
            d = c - CH_ZERO;
        end else if (c inside {[CH_LOWER_A:CH_LOWER_F]}) begin
            d = c - CH_LOWER_A + DIGIT_TEN;
        end else if (c inside {[CH_UPPER_A:CH_UPPER_F]}) begin
            d = c - CH_UPPER_A + DIGIT_TEN;
        end else begin
            ok = 1'b0;
        end
        return {ok, d[3:0]};
    endfunction

endpackage

// ----- rtl/hrcv_byte_map.sv -----
// Byte mapping through two 16-bit carry-less products with the polynomial.
// Depends on nothing; instantiated by hrcv_ctrl.
module hrcv_byte_map (
    input  logic [15:0] i_poly,
    input  logic [7:0]  i_byte,
    output logic [7:0]  o_mapped
);

    function automatic logic [15:0] clmul(input logic [15:0] a, input logic [7:0] b);
        logic [15:0] acc;
        logic [15:0] sh;
        acc = 16'h0000;
        sh  = a;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) begin
                acc = acc ^ sh;
            end
            sh = {sh[14:0], 1'b0};
        end
        return acc;
    endfunction

    logic [15:0] w_first;
    logic [15:0] w_second;

    assign w_first  = clmul(i_poly, i_byte);
    assign w_second = clmul(i_poly, w_first[15:8]);
    assign o_mapped = w_second[7:0];

endmodule

// ----- rtl/hrcv_ctrl.sv -----
// Record parser state, running check sum and mismatch counter.
// Depends on hrcv_pkg and hrcv_byte_map.
module hrcv_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [7:0]        i_char,
    input  logic              i_eoi,
    input  logic [15:0]       i_poly,
    output hrcv_pkg::t_result o_result
);

    hrcv_pkg::t_phase r_phase, n_phase;
    logic        r_pending, n_pending;
    logic [3:0]  r_upper, n_upper;
    logic [1:0]  r_hpos, n_hpos;
    logic [7:0]  r_data_left, n_data_left;
    logic        r_type_nz, n_type_nz;
    logic [7:0]  r_sum, n_sum;
    logic [15:0] r_bad, n_bad;
    logic        r_stopped, n_stopped;

    logic [4:0]  w_hex;
    logic        w_is_hex;
    logic [7:0]  w_byte;
    logic [7:0]  w_mapped;
    logic        w_mis;
    logic [15:0] w_bad_inc;
    logic        w_in_record;

    assign w_hex       = hrcv_pkg::hex_decode(i_char);
    assign w_is_hex    = w_hex[4];
    assign w_byte      = {r_upper, w_hex[3:0]};
    assign w_mis       = (r_sum != w_byte);
    assign w_bad_inc   = (w_mis && (r_bad != hrcv_pkg::COUNT_MAX)) ? r_bad + 16'd1 : r_bad;
    assign w_in_record = (r_phase == hrcv_pkg::PH_HEADER) || (r_phase == hrcv_pkg::PH_DATA)
                         || (r_phase == hrcv_pkg::PH_CHECK);

    hrcv_byte_map u_map (
        .i_poly   (i_poly),
        .i_byte   (w_byte),
        .o_mapped (w_mapped)
    );

    always_comb begin
        n_phase     = r_phase;
        n_pending   = r_pending;
        n_upper     = r_upper;
        n_hpos      = r_hpos;
        n_data_left = r_data_left;
        n_type_nz   = r_type_nz;
        n_sum       = r_sum;
        n_bad       = r_bad;
        n_stopped   = r_stopped;
        if (i_step && !r_stopped) begin
            if (i_eoi) begin
                n_stopped = 1'b1;
            end else begin
                case (r_phase)
                    hrcv_pkg::PH_HUNT: begin
                        if (i_char == hrcv_pkg::CH_COLON) begin
                            n_phase   = hrcv_pkg::PH_HEADER;
                            n_hpos    = hrcv_pkg::HDR_SIZE;
                            n_pending = 1'b0;
                            n_sum     = 8'h00;
                            n_type_nz = 1'b0;
                        end
                    end
                    hrcv_pkg::PH_DISCARD: begin
                        n_phase = hrcv_pkg::PH_HUNT;
                    end
                    hrcv_pkg::PH_HEADER, hrcv_pkg::PH_DATA, hrcv_pkg::PH_CHECK: begin
                        if (!w_is_hex) begin
                            n_stopped = 1'b1;
                        end else if (!r_pending) begin
                            n_upper   = w_hex[3:0];
                            n_pending = 1'b1;
                        end else begin
                            n_pending = 1'b0;
                            if (r_phase == hrcv_pkg::PH_CHECK) begin
                                n_bad = w_bad_inc;
                                if (r_type_nz) begin
                                    n_stopped = 1'b1;
                                end else begin
                                    n_phase = hrcv_pkg::PH_DISCARD;
                                end
                            end else begin
                                n_sum = r_sum ^ w_mapped;
                                if (r_phase == hrcv_pkg::PH_HEADER) begin
                                    if (r_hpos == hrcv_pkg::HDR_SIZE) begin
                                        n_data_left = w_byte;
                                    end
                                    if (r_hpos == hrcv_pkg::HDR_TYPE) begin
                                        n_type_nz = (w_byte != 8'h00);
                                        n_phase   = (r_data_left != 8'h00) ?
                                                    hrcv_pkg::PH_DATA : hrcv_pkg::PH_CHECK;
                                        n_hpos    = hrcv_pkg::HDR_SIZE;
                                    end else begin
                                        n_hpos = r_hpos + 2'd1;
                                    end
                                end else begin
                                    n_data_left = r_data_left - 8'd1;
                                    if (r_data_left == 8'd1) begin
                                        n_phase = hrcv_pkg::PH_CHECK;
                                    end
                                end
                            end
                        end
                    end
                    default: begin
                        n_phase = hrcv_pkg::PH_HUNT;
                    end
                endcase
            end
        end
    end

    always_comb begin
        o_result                = '0;
        o_result.mismatch_count = r_bad;
        if (!r_stopped) begin
            if (i_eoi) begin
                o_result.valid  = 1'b1;
                o_result.status = hrcv_pkg::ST_END;
            end else if (w_in_record && !w_is_hex) begin
                o_result.valid  = 1'b1;
                o_result.status = hrcv_pkg::ST_CORRUPT;
            end else if ((r_phase == hrcv_pkg::PH_CHECK) && r_pending) begin
                o_result.valid          = 1'b1;
                o_result.status         = hrcv_pkg::ST_OK;
                o_result.calculated     = r_sum;
                o_result.received       = w_byte;
                o_result.mismatch       = w_mis;
                o_result.mismatch_count = w_bad_inc;
                o_result.final_record   = r_type_nz;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= hrcv_pkg::PH_HUNT;
            r_pending   <= 1'b0;
            r_upper     <= 4'h0;
            r_hpos      <= hrcv_pkg::HDR_SIZE;
            r_data_left <= 8'h00;
            r_type_nz   <= 1'b0;
            r_sum       <= 8'h00;
            r_bad       <= 16'h0000;
            r_stopped   <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_pending   <= n_pending;
            r_upper     <= n_upper;
            r_hpos      <= n_hpos;
            r_data_left <= n_data_left;
            r_type_nz   <= n_type_nz;
            r_sum       <= n_sum;
            r_bad       <= n_bad;
            r_stopped   <= n_stopped;
        end
    end

endmodule

// ----- rtl/hex_record_checksum_verifier.sv -----
// A request is held in the input register until the parser steps on it; any result
// is then written to the result register, which raises o_out_valid.
// Throughput: one character per cycle; the parser sits between an input register
// and a result register, and only a stalled full result register holds off input.
// Reset (synchronous, active low) clears the parser, the mismatch count and both valid
// flags, and sets the polynomial register to 0x169. Depends on hrcv_pkg and hrcv_ctrl.
module hex_record_checksum_verifier (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_char_in,
    input  logic        i_end_of_input,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [7:0]  o_calculated,
    output logic [7:0]  o_received,
    output logic        o_mismatch,
    output logic [15:0] o_mismatch_count,
    output logic        o_final_record,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata
);

    logic              r_in_valid, n_in_valid;
    logic [7:0]        r_char;
    logic              r_eoi;
    logic [15:0]       r_poly;
    logic              r_out_valid, n_out_valid;
    hrcv_pkg::t_result r_res;
    hrcv_pkg::t_result w_result;
    logic              w_step;
    logic              w_in_take;

    assign w_step     = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_step;
    assign w_in_take  = i_in_valid && !o_in_stall;

    hrcv_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_char   (r_char),
        .i_eoi    (r_eoi),
        .i_poly   (r_poly),
        .o_result (w_result)
    );

    always_comb begin
        n_in_valid = r_in_valid;
        if (w_in_take) begin
            n_in_valid = 1'b1;
        end else if (w_step) begin
            n_in_valid = 1'b0;
        end
        n_out_valid = r_out_valid && i_out_stall;
        if (w_step && w_result.valid) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_poly      <= hrcv_pkg::POLY_RESET;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_poly <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_char <= i_char_in;
            r_eoi  <= i_end_of_input;
        end
        if (w_step && w_result.valid) begin
            r_res <= w_result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_res.status;
    assign o_calculated     = r_res.calculated;
    assign o_received       = r_res.received;
    assign o_mismatch       = r_res.mismatch;
    assign o_mismatch_count = r_res.mismatch_count;
    assign o_final_record   = r_res.final_record;

endmodule

// ----- rtl/hrcv_checker.sv -----
// Port-level checker for the record checker, bound to the top level.
// Depends on hrcv_pkg and hex_record_checksum_verifier_defines.svh.
`include "hex_record_checksum_verifier_defines.svh"

module hrcv_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [1:0]  o_status,
    input logic [7:0]  o_calculated,
    input logic [7:0]  o_received,
    input logic        o_mismatch,
    input logic [15:0] o_mismatch_count,
    input logic        o_final_record
);

    `HRCV_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_status) && $stable(o_calculated) && $stable(o_received) && $stable(o_mismatch_count), "Stalled result changed.")
    `HRCV_ASSERT_NOW(a_err_fields, o_out_valid && (o_status != hrcv_pkg::ST_OK), (o_calculated == 8'h00) && (o_received == 8'h00) && !o_mismatch && !o_final_record, "Error result carries record fields.")
    `HRCV_ASSERT_NOW(a_mis_flag, o_out_valid && (o_status == hrcv_pkg::ST_OK), o_mismatch == (o_calculated != o_received), "Mismatch flag disagrees with check values.")
    `HRCV_ASSERT_NEXT(a_halt, o_out_valid && !i_out_stall && ((o_status != hrcv_pkg::ST_OK) || o_final_record), !o_out_valid, "Result followed a halting request.")

endmodule

bind hex_record_checksum_verifier hrcv_checker u_checker (.*);

// ----- bench/hex_record_checksum_verifier_tb.sv -----
// Self-checking bench for the hex record checksum verifier: text streams of records,
// noise and one closing event, predicted character by character in the bench.
// Depends on hrcv_pkg and the hex_record_checksum_verifier module only.
`timescale 1ns / 100ps

module hex_record_checksum_verifier_tb;

    typedef struct {
        logic [7:0] ch;
        logic       eoi;
    } t_text_char;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  calc;
        logic [7:0]  recv;
        logic        mism;
        logic [15:0] count;
        logic        fin;
    } t_verdict;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic [7:0]  char_drv = 8'h00;
    logic        eoi_drv = 1'b0;
    logic        out_stall = 1'b0;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_wdata = 16'h0000;

    logic        o_in_stall;
    logic        o_out_valid;
    logic [1:0]  o_status;
    logic [7:0]  o_calculated;
    logic [7:0]  o_received;
    logic        o_mismatch;
    logic [15:0] o_mismatch_count;
    logic        o_final_record;

    t_text_char  pending_chars[$];
    t_verdict    pending_verdicts[$];
    t_text_char  next_char;
    t_verdict    want;
    t_verdict    got;

    // Bench copy of the parser state and of the polynomial register.
    logic [15:0]      poly_now = hrcv_pkg::POLY_RESET;
    hrcv_pkg::t_phase parse_phase = hrcv_pkg::PH_HUNT;
    logic             have_upper = 1'b0;
    logic [3:0]       upper_digit = 4'h0;
    logic [1:0]       hdr_idx = 2'd0;
    logic [7:0]       bytes_left = 8'h00;
    logic             last_rec = 1'b0;
    logic [7:0]       check_sum = 8'h00;
    logic [15:0]      bad_count = 16'h0000;
    logic             halted = 1'b0;

    int          burst_left = 0;
    int          gap_left = 0;
    logic [15:0] stall_bits = 16'h0000;
    logic [5:0]  stall_age = 6'd0;

    int          phase_chars = 0;
    int          chars_sent = 0;
    int          verdicts_checked = 0;
    int          verdict_errors = 0;
    int          poly_writes = 0;
    string       closing_kind = "none";

    hex_record_checksum_verifier DUT (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (o_in_stall),
        .i_char_in        (char_drv),
        .i_end_of_input   (eoi_drv),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (out_stall),
        .o_status         (o_status),
        .o_calculated     (o_calculated),
        .o_received       (o_received),
        .o_mismatch       (o_mismatch),
        .o_mismatch_count (o_mismatch_count),
        .o_final_record   (o_final_record),
        .i_cfg_we         (cfg_we),
        .i_cfg_wdata      (cfg_wdata)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic logic [15:0] gf2_product(input logic [15:0] a, input logic [7:0] b);
        logic [15:0] acc;
        acc = 16'h0000;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) begin
                acc = acc ^ (a << i);
            end
        end
        return acc;
    endfunction

    function automatic logic [7:0] byte_map(input logic [7:0] b);
        logic [15:0] upper_part;
        logic [15:0] folded;
        upper_part = gf2_product(poly_now, b);
        folded     = gf2_product(poly_now, upper_part[15:8]);
        return folded[7:0];
    endfunction

    function automatic int digit_value(input logic [7:0] c);
        if (c >= hrcv_pkg::CH_ZERO && c <= hrcv_pkg::CH_NINE) begin
            return int'(c - hrcv_pkg::CH_ZERO);
        end else if (c >= hrcv_pkg::CH_LOWER_A && c <= hrcv_pkg::CH_LOWER_F) begin
            return int'(c - hrcv_pkg::CH_LOWER_A) + int'(hrcv_pkg::DIGIT_TEN);
        end else if (c >= hrcv_pkg::CH_UPPER_A && c <= hrcv_pkg::CH_UPPER_F) begin
            return int'(c - hrcv_pkg::CH_UPPER_A) + int'(hrcv_pkg::DIGIT_TEN);
        end
        return -1;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
        if (n < hrcv_pkg::DIGIT_TEN[3:0] || hrcv_pkg::DIGIT_TEN > 8'd15) begin
            return hrcv_pkg::CH_ZERO + 8'(n);
        end
        return (upper ? hrcv_pkg::CH_UPPER_A : hrcv_pkg::CH_LOWER_A) + 8'(n)
               - hrcv_pkg::DIGIT_TEN;
    endfunction

    task automatic push_error(input logic [1:0] code);
        pending_verdicts.push_back('{code, 8'h00, 8'h00, 1'b0, bad_count, 1'b0});
        halted = 1'b1;
    endtask

    // Advances the bench parser by one accepted request.
    task automatic parse_char(input logic [7:0] c, input logic eoi);
        int         d;
        logic [7:0] b;
        logic       differ;
        if (halted) begin
            return;
        end
        if (eoi) begin
            push_error(hrcv_pkg::ST_END);
            return;
        end
        case (parse_phase)
            hrcv_pkg::PH_HUNT: begin
                if (c == hrcv_pkg::CH_COLON) begin
                    parse_phase = hrcv_pkg::PH_HEADER;
                    hdr_idx     = hrcv_pkg::HDR_SIZE;
                    have_upper  = 1'b0;
                    check_sum   = 8'h00;
                    last_rec    = 1'b0;
                end
            end
            hrcv_pkg::PH_DISCARD: begin
                parse_phase = hrcv_pkg::PH_HUNT;
            end
            default: begin
                d = digit_value(c);
                if (d < 0) begin
                    push_error(hrcv_pkg::ST_CORRUPT);
                end else if (!have_upper) begin
                    upper_digit = d[3:0];
                    have_upper  = 1'b1;
                end else begin
                    have_upper = 1'b0;
                    b = {upper_digit, d[3:0]};
                    if (parse_phase == hrcv_pkg::PH_CHECK) begin
                        differ = (check_sum != b);
                        if (differ && bad_count != hrcv_pkg::COUNT_MAX) begin
                            bad_count = bad_count + 16'd1;
                        end
                        pending_verdicts.push_back('{hrcv_pkg::ST_OK, check_sum, b, differ,
                                                     bad_count, last_rec});
                        if (last_rec) begin
                            halted = 1'b1;
                        end else begin
                            parse_phase = hrcv_pkg::PH_DISCARD;
                        end
                    end else begin
                        check_sum = check_sum ^ byte_map(b);
                        if (parse_phase == hrcv_pkg::PH_HEADER) begin
                            if (hdr_idx == hrcv_pkg::HDR_SIZE) begin
                                bytes_left = b;
                            end
                            if (hdr_idx == hrcv_pkg::HDR_TYPE) begin
                                last_rec    = (b != 8'h00);
                                parse_phase = (bytes_left != 8'h00) ? hrcv_pkg::PH_DATA
                                                                    : hrcv_pkg::PH_CHECK;
                                hdr_idx     = hrcv_pkg::HDR_SIZE;
                            end else begin
                                hdr_idx = hdr_idx + 2'd1;
                            end
                        end else begin
                            bytes_left = bytes_left - 8'd1;
                            if (bytes_left == 8'h00) begin
                                parse_phase = hrcv_pkg::PH_CHECK;
                            end
                        end
                    end
                end
            end
        endcase
    endtask

    task automatic send_char(input logic [7:0] c, input logic eoi);
        pending_chars.push_back('{c, eoi});
        phase_chars++;
    endtask

    task automatic send_noise();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(0, 255));
        end while (c == hrcv_pkg::CH_COLON);
        send_char(c, 1'b0);
    endtask

    // Case choice: 0 lower, 1 upper, otherwise random per digit.
    task automatic send_byte(input logic [7:0] b, input int case_mode);
        bit up_hi;
        bit up_lo;
        up_hi = (case_mode == 1) || (case_mode > 1 && $urandom_range(0, 1) == 1);
        up_lo = (case_mode == 1) || (case_mode > 1 && $urandom_range(0, 1) == 1);
        send_char(hex_char(b[7:4], up_hi), 1'b0);
        send_char(hex_char(b[3:0], up_lo), 1'b0);
    endtask

    task automatic send_record(input int len, input logic [15:0] addr, input logic [7:0] kind,
                               input bit bad_check, input int case_mode);
        logic [7:0] fields[$];
        logic [7:0] sum;
        logic [7:0] flip;
        fields = {};
        sum = 8'h00;
        fields.push_back(8'(len));
        fields.push_back(addr[15:8]);
        fields.push_back(addr[7:0]);
        fields.push_back(kind);
        repeat (len) fields.push_back(8'($urandom_range(0, 255)));
        foreach (fields[i]) sum = sum ^ byte_map(fields[i]);
        if (bad_check) begin
            flip = 8'($urandom_range(1, 255));
            sum  = sum ^ flip;
        end
        send_char(hrcv_pkg::CH_COLON, 1'b0);
        foreach (fields[i]) send_byte(fields[i], case_mode);
        send_byte(sum, case_mode);
    endtask

    task automatic send_random_record();
        int len;
        len = ($urandom_range(0, 39) == 0) ? $urandom_range(16, 255) : $urandom_range(0, 6);
        repeat ($urandom_range(0, 3)) send_noise();
        send_record(len, 16'($urandom_range(0, 65535)), 8'h00, $urandom_range(0, 99) < 15, 2);
        send_char(8'($urandom_range(0, 255)), 1'b0);
    endtask

    task automatic wait_idle();
        do begin
            @(posedge clk);
        end while (pending_chars.size() != 0 || in_valid || pending_verdicts.size() != 0);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_poly(input logic [15:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
        poly_now = value;
        poly_writes++;
    endtask

    task automatic note_error(input string what);
        verdict_errors++;
        if (verdict_errors <= 10) begin
            $display("%0t: %s", $realtime, what);
        end
    endtask

    // Request side: bursts of random length separated by random gaps.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid   <= 1'b0;
            burst_left <= 0;
            gap_left   <= 0;
        end else begin
            if (in_valid && !o_in_stall) begin
                parse_char(char_drv, eoi_drv);
                chars_sent++;
            end
            if (!in_valid || !o_in_stall) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end else if (pending_chars.size() != 0) begin
                    next_char = pending_chars.pop_front();
                    char_drv <= next_char.ch;
                    eoi_drv  <= next_char.eoi;
                    in_valid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall  <= 1'b0;
            stall_bits <= 16'h0000;
            stall_age  <= 6'd0;
        end else begin
            if (stall_age == 6'd0) begin
                case ($urandom_range(0, 3))
                    0: stall_bits <= 16'h0000;
                    1: stall_bits <= 16'($urandom);
                    2: stall_bits <= 16'($urandom | $urandom);
                    default: stall_bits <= 16'($urandom & $urandom);
                endcase
            end else begin
                stall_bits <= {stall_bits[14:0], stall_bits[15]};
            end
            stall_age <= stall_age + 6'd1;
            out_stall <= stall_bits[0];
        end
    end

    always @(posedge clk) begin
        if (rst_n && o_out_valid && !out_stall) begin
            got = '{o_status, o_calculated, o_received, o_mismatch, o_mismatch_count,
                    o_final_record};
            if (pending_verdicts.size() == 0) begin
                note_error($sformatf("result with nothing expected: status %0d calc %02h",
                                     got.status, got.calc));
            end else begin
                want = pending_verdicts.pop_front();
                verdicts_checked++;
                if (got.status !== want.status || got.calc !== want.calc ||
                    got.recv !== want.recv || got.mism !== want.mism ||
                    got.count !== want.count || got.fin !== want.fin) begin
                    note_error({$sformatf(
                        "expected st %0d calc %02h recv %02h mis %0b cnt %0d fin %0b",
                        want.status, want.calc, want.recv, want.mism, want.count, want.fin),
                        $sformatf(", got st %0d calc %02h recv %02h mis %0b cnt %0d fin %0b",
                        got.status, got.calc, got.recv, got.mism, got.count, got.fin)});
                end
            end
        end
    end

    initial begin
        logic [15:0] poly_plan[$];
        int          digits;
        logic [7:0]  bad_char;
        poly_plan = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000};
        repeat (4) poly_plan.push_back(16'($urandom_range(0, 65535)));
        poly_plan.push_back(hrcv_pkg::POLY_RESET);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Opening checks run on the reset polynomial.
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b0);
        send_record(0, 16'h0000, 8'h00, 1'b0, 1);
        send_char(hrcv_pkg::CH_COLON, 1'b0);
        send_record(1, 16'hFFFF, 8'h00, 1'b1, 0);
        send_char(8'h80, 1'b0);
        wait_idle();

        foreach (poly_plan[p]) begin
            write_poly(poly_plan[p]);
            phase_chars = 0;
            while (phase_chars < 120) send_random_record();
            if (p == poly_plan.size() - 1) begin
                case ($urandom_range(0, 4))
                    0: begin
                        closing_kind = "final record";
                        send_record($urandom_range(0, 4), 16'($urandom_range(0, 65535)),
                                    8'($urandom_range(1, 255)), $urandom_range(0, 1), 2);
                    end
                    1: begin
                        closing_kind = "corrupt character";
                        send_char(hrcv_pkg::CH_COLON, 1'b0);
                        digits = $urandom_range(0, 9);
                        repeat (digits) send_char(hex_char(4'($urandom_range(0, 15)), 1'b1),
                                                  1'b0);
                        do begin
                            bad_char = 8'($urandom_range(0, 255));
                        end while (digit_value(bad_char) >= 0);
                        send_char(bad_char, 1'b0);
                    end
                    2: begin
                        closing_kind = "end of input while hunting";
                        send_noise();
                        send_char(8'($urandom_range(0, 255)), 1'b1);
                    end
                    3: begin
                        closing_kind = "end of input inside a record";
                        send_char(hrcv_pkg::CH_COLON, 1'b0);
                        digits = $urandom_range(0, 9);
                        repeat (digits) send_char(hex_char(4'($urandom_range(0, 15)), 1'b0),
                                                  1'b0);
                        send_char(8'($urandom_range(0, 255)), 1'b1);
                    end
                    default: begin
                        closing_kind = "end of input at the discarded character";
                        send_record($urandom_range(0, 4), 16'($urandom_range(0, 65535)), 8'h00,
                                    1'b0, 2);
                        send_char(8'($urandom_range(0, 255)), 1'b1);
                    end
                endcase
                // The block has stopped; these requests must produce nothing.
                repeat (4) send_char(8'($urandom_range(0, 255)), 1'b0);
                send_char(hrcv_pkg::CH_COLON, 1'b0);
                send_char(8'($urandom_range(0, 255)), 1'b1);
            end
            wait_idle();
        end

        repeat (20) @(posedge clk);
        if (pending_verdicts.size() != 0) begin
            note_error($sformatf("%0d expected results never arrived", pending_verdicts.size()));
        end
        $display("Sent %0d characters under %0d polynomial settings; %0d results checked.",
                 chars_sent, poly_writes + 1, verdicts_checked);
        $display("Stream closed by %s; %0d check errors found.", closing_kind, verdict_errors);
        if (verdict_errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
